// ===== hdl/sst_pkg.sv =====
// shared types, constants and helpers for the sorted set table
package sst_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_WIDTH = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  // fixed widths of the item and result fields
  localparam int CMD_W   = 2;
  localparam int KEY_W   = 32;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  localparam logic [KEY_WIDTH-1:0] KEY_MSB_MASK = {1'b1, {(KEY_WIDTH - 1){1'b0}}};

  typedef logic [KEY_WIDTH-1:0] key_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;
  } item_t;

  typedef struct packed {
    logic               hit;
    logic               changed;
    logic               full_res;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] count;
  } result_t;

  typedef struct packed {
    logic load;
    logic shift_up;
    logic shift_down;
  } cell_ctl_t;

  function automatic logic [IDX_W-1:0] onehot_index(input logic [CAPACITY-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (v[i]) idx = idx | IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

// ===== hdl/sst_cell.sv =====
// one table slot: holds a key, compares it against the probe, shifts with its neighbors
module sst_cell (
  input  logic              clk,
  input  logic              compare,
  input  sst_pkg::key_t     probe,
  input  logic              signed_keys,
  input  logic              valid,
  input  sst_pkg::cell_ctl_t ctl,
  input  sst_pkg::key_t     lower,
  input  sst_pkg::key_t     upper,
  output sst_pkg::key_t     entry,
  output logic              eq,
  output logic              gt
);

  sst_pkg::key_t flip;
  logic          eq_now;
  logic          gt_now;

  // flipping the sign bit turns a signed order into an unsigned one
  assign flip   = signed_keys ? sst_pkg::KEY_MSB_MASK : '0;
  assign eq_now = valid && (entry == probe);
  assign gt_now = valid && ((entry ^ flip) > (probe ^ flip));

  always_ff @(posedge clk) begin
    if (compare) begin
      eq <= eq_now;
      gt <= gt_now;
    end
    if (ctl.load) begin
      entry <= probe;
    end else if (ctl.shift_up) begin
      entry <= lower;
    end else if (ctl.shift_down) begin
      entry <= upper;
    end
  end

endmodule

// ===== hdl/sorted_set_table_top.sv =====
// sorted set table: top level with command sequencing, flag scan and the row of cells
//
// At the edge that accepts start every cell registers whether its key equals or
// orders above the command's key, and in the following cycle the flags are
// scanned for the lowest match and the row shifts up or down by one slot in a
// single step. busy is high for that one cycle; no command is taken while busy.
// The result appears with done for exactly one cycle, the cycle after busy; it
// cannot be held off and must be taken then. A start in that same cycle is
// accepted. The key order register must be written with cfg_we only while no
// command is in flight (not enforced by the block). After reset the table is empty.
module sorted_set_table_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  sst_pkg::item_t   item,
  output logic             busy,
  output logic             done,
  output sst_pkg::result_t result,
  input  logic             cfg_we,
  input  logic             cfg_data
);

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t                      state;
  state_t                      state_next;
  logic                        signed_keys;
  logic [sst_pkg::CMD_W-1:0]   cmd_q;
  sst_pkg::key_t               key_q;
  logic [sst_pkg::CNT_W-1:0]   count;
  logic [sst_pkg::CNT_W-1:0]   count_next;
  sst_pkg::result_t            result_next;

  logic                        accept;
  sst_pkg::key_t               probe;
  sst_pkg::key_t               entry [sst_pkg::CAPACITY];
  sst_pkg::cell_ctl_t          ctl   [sst_pkg::CAPACITY];
  logic [sst_pkg::CAPACITY-1:0] valid;
  logic [sst_pkg::CAPACITY-1:0] at_end;
  logic [sst_pkg::CAPACITY-1:0] eq_vec;
  logic [sst_pkg::CAPACITY-1:0] gt_vec;
  logic [sst_pkg::CAPACITY-1:0] eq_low;
  logic [sst_pkg::CAPACITY-1:0] eq_below;
  logic [sst_pkg::CAPACITY-1:0] gt_low;
  logic [sst_pkg::CAPACITY-1:0] gt_below;
  logic                        hit;
  logic                        any_gt;
  logic                        is_full;
  logic                        do_ins;
  logic                        do_del;
  logic [sst_pkg::IDX_W-1:0]   hit_pos;
  logic [sst_pkg::IDX_W-1:0]   ins_pos;

  assign busy   = (state == ST_SCAN);
  assign accept = start && !busy;
  // the port key is compared at accept, the held key is written during the scan
  assign probe  = busy ? key_q : item.key[sst_pkg::KEY_WIDTH-1:0];

  // lowest set flag and the flags below it
  assign eq_below = (eq_vec - sst_pkg::CAPACITY'(1)) & ~eq_vec;
  assign eq_low   = eq_vec & ~(eq_vec - sst_pkg::CAPACITY'(1));
  assign gt_below = (gt_vec - sst_pkg::CAPACITY'(1)) & ~gt_vec;
  assign gt_low   = gt_vec & ~(gt_vec - sst_pkg::CAPACITY'(1));

  assign hit     = |eq_vec;
  assign any_gt  = |gt_vec;
  assign is_full = (count == sst_pkg::CNT_W'(sst_pkg::CAPACITY));
  assign do_ins  = busy && (cmd_q == sst_pkg::CMD_INSERT) && !hit && !is_full;
  assign do_del  = busy && (cmd_q == sst_pkg::CMD_DELETE) && hit;
  assign hit_pos = sst_pkg::onehot_index(eq_low);
  // with no greater entry the key goes at the end
  assign ins_pos = any_gt ? sst_pkg::onehot_index(gt_low) : count[sst_pkg::IDX_W-1:0];

  for (genvar i = 0; i < sst_pkg::CAPACITY; i++) begin : g_cell
    sst_pkg::key_t lower_key;
    sst_pkg::key_t upper_key;

    assign valid[i]  = (count > sst_pkg::CNT_W'(i));
    assign at_end[i] = (count == sst_pkg::CNT_W'(i));

    assign ctl[i].load       = do_ins && (any_gt ? gt_low[i] : at_end[i]);
    assign ctl[i].shift_up   = do_ins && any_gt && !gt_below[i] && !gt_low[i];
    assign ctl[i].shift_down = do_del && !eq_below[i];

    if (i == 0) begin : g_first
      assign lower_key = entry[i];
    end else begin : g_lower
      assign lower_key = entry[i-1];
    end
    if (i == sst_pkg::CAPACITY - 1) begin : g_last
      assign upper_key = entry[i];
    end else begin : g_upper
      assign upper_key = entry[i+1];
    end

    sst_cell u_cell (
      .clk         (clk),
      .compare     (accept),
      .probe       (probe),
      .signed_keys (signed_keys),
      .valid       (valid[i]),
      .ctl         (ctl[i]),
      .lower       (lower_key),
      .upper       (upper_key),
      .entry       (entry[i]),
      .eq          (eq_vec[i]),
      .gt          (gt_vec[i])
    );
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    result_next = result;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        state_next = ST_IDLE;
        if (do_ins) count_next = count + sst_pkg::CNT_W'(1);
        else if (do_del) count_next = count - sst_pkg::CNT_W'(1);
        result_next.hit      = hit;
        result_next.changed  = do_ins || do_del;
        result_next.full_res = (cmd_q == sst_pkg::CMD_INSERT) && !hit && is_full;
        if (hit) result_next.position = sst_pkg::POS_W'(hit_pos);
        else if (do_ins) result_next.position = sst_pkg::POS_W'(ins_pos);
        else result_next.position = '0;
        result_next.count = sst_pkg::COUNT_W'(count_next);
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      done        <= 1'b0;
      count       <= '0;
      signed_keys <= 1'b0;
    end else begin
      state <= state_next;
      done  <= busy;
      count <= count_next;
      if (cfg_we) signed_keys <= cfg_data;
    end
    if (accept) begin
      cmd_q <= item.command;
      key_q <= item.key[sst_pkg::KEY_WIDTH-1:0];
    end
    result <= result_next;
  end

  a_done_follows_scan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_SCAN))
    else $error("result strobe without a scan cycle");

  a_accept_to_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted command did not enter the scan cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sst_pkg::CNT_W'(sst_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  a_result_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.count == sst_pkg::COUNT_W'(count)))
    else $error("reported count differs from the table");

  a_full_refusal: assert property (@(posedge clk) disable iff (rst)
    (done && result.full_res) |-> (!result.changed && !result.hit && $stable(count)))
    else $error("refused insert changed the table");

endmodule
